// ===== src/assert_macros.svh =====
// Assertion macros used by the checked RTL file, the pose frame transform top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Checks that the consequent holds whenever the antecedent does.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/pft_pkg.sv =====
// Types, constants and the arctangent table of the pose frame transform.
`default_nettype none

package pft_pkg;

    localparam int COORD_IN_W   = 32;
    localparam int HEAD_W       = 16;
    localparam int DIFF_W       = COORD_IN_W + 1;
    localparam int GUARD        = 8;
    localparam int VEC_W        = 44;
    localparam int ANG_W        = 32;
    localparam int GAIN_W       = 21;
    localparam int GAIN_SHIFT   = 20;
    localparam int PROD_W       = VEC_W + GAIN_W;
    localparam int SHIFT_TOTAL  = GAIN_SHIFT + GUARD;
    localparam int RND_W        = PROD_W - SHIFT_TOTAL;
    localparam int SUM_W        = RND_W + 1;
    localparam int ATAN_ENTRIES = 32;

    localparam logic signed [GAIN_W-1:0] GAIN_Q20 = 21'sd636751;

    localparam logic OP_L2G = 1'b0;
    localparam logic OP_G2L = 1'b1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] r;
    } pft_rot_t;

    typedef struct packed {
        logic                         op;
        logic signed [COORD_IN_W-1:0] ref_x;
        logic signed [COORD_IN_W-1:0] ref_y;
        logic        [HEAD_W-1:0]     heading;
        logic        [COORD_IN_W-1:0] curvature;
        logic        [COORD_IN_W-1:0] arc_length;
    } pft_side_t;

    function automatic logic [ANG_W-1:0] pft_atan(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000028;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000002;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/pft_cordic_stage.sv =====
// One registered CORDIC micro-rotation stage with its own valid and ready.
`default_nettype none

module pft_cordic_stage
    import pft_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_vld,
    input  wire pft_rot_t  in_rot,
    input  wire pft_side_t in_side,
    output logic           in_rdy,
    output logic           out_vld,
    output pft_rot_t       out_rot,
    output pft_side_t      out_side,
    input  wire logic      out_rdy
);

    localparam int SHIFT = STAGE % ATAN_ENTRIES;

    logic                    vld_reg;
    pft_rot_t                rot_reg;
    pft_side_t               side_reg;
    pft_rot_t                rot_next;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [ANG_W-1:0] step;

    assign in_rdy = !vld_reg || out_rdy;

    always_comb begin
        dx   = in_rot.y >>> SHIFT;
        dy   = in_rot.x >>> SHIFT;
        step = $signed(pft_atan(5'(SHIFT)));
        if (!in_rot.r[ANG_W-1]) begin
            rot_next.x = in_rot.x - dx;
            rot_next.y = in_rot.y + dy;
            rot_next.r = in_rot.r - step;
        end else begin
            rot_next.x = in_rot.x + dx;
            rot_next.y = in_rot.y - dy;
            rot_next.r = in_rot.r + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_rdy) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy && in_vld) begin
            rot_reg  <= rot_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rot  = rot_reg;
    assign out_side = side_reg;

endmodule

`default_nettype wire

// ===== src/pose_frame_transform_unit.sv =====
// Top level of the planar pose frame transform pipeline.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   operation, reference pose, target pose
//   m_       out        m_valid / m_ready   transformed x, y, heading, curvature, arc
//
// One item enters per cycle while the output is not blocked; each item passes
// the capture and quadrant registers, the chain of CORDIC stages, and the gain
// multiply, rounding and output registers. Every stage holds its own valid bit
// and stalls only when the stage after it is full and stalled, so bubbles are absorbed.
// Reset is synchronous and active low and clears the valid bits only.
`default_nettype none
`include "assert_macros.svh"

module pose_frame_transform_unit
    import pft_pkg::*;
#(
    parameter int ROTATION_STAGES = 16,
    parameter int COORD_WIDTH     = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_operation,
    input  wire logic signed [COORD_IN_W-1:0] s_ref_x,
    input  wire logic signed [COORD_IN_W-1:0] s_ref_y,
    input  wire logic        [HEAD_W-1:0]     s_ref_heading,
    input  wire logic signed [COORD_IN_W-1:0] s_tgt_x,
    input  wire logic signed [COORD_IN_W-1:0] s_tgt_y,
    input  wire logic        [HEAD_W-1:0]     s_tgt_heading,
    input  wire logic signed [COORD_IN_W-1:0] s_tgt_curvature,
    input  wire logic signed [COORD_IN_W-1:0] s_tgt_arc_length,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed      [COORD_IN_W-1:0] m_out_x,
    output logic signed      [COORD_IN_W-1:0] m_out_y,
    output logic             [HEAD_W-1:0]     m_out_heading,
    output logic signed      [COORD_IN_W-1:0] m_out_curvature,
    output logic signed      [COORD_IN_W-1:0] m_out_arc_length
);

    localparam int SAT_W = (COORD_WIDTH > COORD_IN_W) ? COORD_IN_W : COORD_WIDTH;
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (SAT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (SHIFT_TOTAL - 1);

    // Capture stage: input vector (difference vector for global-to-local), rotation angle and sideband.
    logic                     s1_vld_reg;
    logic signed [DIFF_W-1:0] s1_vx_reg;
    logic signed [DIFF_W-1:0] s1_vy_reg;
    logic        [HEAD_W-1:0] s1_ang_reg;
    pft_side_t                s1_side_reg;
    logic signed [DIFF_W-1:0] s1_vx_next;
    logic signed [DIFF_W-1:0] s1_vy_next;
    logic        [HEAD_W-1:0] s1_ang_next;
    pft_side_t                s1_side_next;
    logic                     s1_rdy;

    // Quadrant stage.
    logic                    s2_vld_reg;
    pft_rot_t                s2_rot_reg;
    pft_side_t               s2_side_reg;
    pft_rot_t                s2_rot_next;
    logic signed [VEC_W-1:0] s2_xs;
    logic signed [VEC_W-1:0] s2_ys;
    logic                    s2_rdy;

    // CORDIC chain.
    logic      [ROTATION_STAGES:0] cd_vld;
    logic      [ROTATION_STAGES:0] cd_rdy;
    pft_rot_t                      cd_rot  [0:ROTATION_STAGES];
    pft_side_t                     cd_side [0:ROTATION_STAGES];

    // Gain multiply stage.
    logic                     mul_vld_reg;
    logic signed [PROD_W-1:0] mul_px_reg;
    logic signed [PROD_W-1:0] mul_py_reg;
    pft_side_t                mul_side_reg;
    logic                     mul_rdy;

    // Rounding stage.
    logic                    rnd_vld_reg;
    logic signed [RND_W-1:0] rnd_x_reg;
    logic signed [RND_W-1:0] rnd_y_reg;
    pft_side_t               rnd_side_reg;
    logic signed [RND_W-1:0] rnd_x_next;
    logic signed [RND_W-1:0] rnd_y_next;
    logic                    rnd_rdy;

    // Output register.
    logic                         out_vld_reg;
    logic                         out_op_reg;
    logic signed [COORD_IN_W-1:0] out_x_reg;
    logic signed [COORD_IN_W-1:0] out_y_reg;
    logic        [HEAD_W-1:0]     out_heading_reg;
    logic        [COORD_IN_W-1:0] out_curvature_reg;
    logic        [COORD_IN_W-1:0] out_arc_reg;
    logic signed [SUM_W-1:0]      sum_x;
    logic signed [SUM_W-1:0]      sum_y;
    logic signed [COORD_IN_W-1:0] out_x_next;
    logic signed [COORD_IN_W-1:0] out_y_next;
    logic                         out_rdy;

    assign out_rdy = !out_vld_reg || m_ready;
    assign rnd_rdy = !rnd_vld_reg || out_rdy;
    assign mul_rdy = !mul_vld_reg || rnd_rdy;
    assign s2_rdy  = !s2_vld_reg || cd_rdy[0];
    assign s1_rdy  = !s1_vld_reg || s2_rdy;
    assign s_ready = s1_rdy;

    always_comb begin
        s1_side_next.op        = s_operation;
        s1_side_next.ref_x     = s_ref_x;
        s1_side_next.ref_y     = s_ref_y;
        s1_side_next.curvature = s_tgt_curvature;
        if (s_operation == OP_G2L) begin
            s1_vx_next              = DIFF_W'(s_tgt_x) - DIFF_W'(s_ref_x);
            s1_vy_next              = DIFF_W'(s_tgt_y) - DIFF_W'(s_ref_y);
            s1_ang_next             = HEAD_W'(0) - s_ref_heading;
            s1_side_next.heading    = s_tgt_heading - s_ref_heading;
            s1_side_next.arc_length = '0;
        end else begin
            s1_vx_next              = DIFF_W'(s_tgt_x);
            s1_vy_next              = DIFF_W'(s_tgt_y);
            s1_ang_next             = s_ref_heading;
            s1_side_next.heading    = s_tgt_heading + s_ref_heading;
            s1_side_next.arc_length = s_tgt_arc_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s1_rdy) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy && s_valid) begin
            s1_vx_reg   <= s1_vx_next;
            s1_vy_reg   <= s1_vy_next;
            s1_ang_reg  <= s1_ang_next;
            s1_side_reg <= s1_side_next;
        end
    end

    always_comb begin
        s2_xs         = VEC_W'($signed({s1_vx_reg, {GUARD{1'b0}}}));
        s2_ys         = VEC_W'($signed({s1_vy_reg, {GUARD{1'b0}}}));
        s2_rot_next.r = $signed({2'b00, s1_ang_reg[HEAD_W-3:0], {(ANG_W - HEAD_W){1'b0}}});
        case (s1_ang_reg[HEAD_W-1:HEAD_W-2])
            QUAD_1: begin
                s2_rot_next.x = -s2_ys;
                s2_rot_next.y = s2_xs;
            end
            QUAD_2: begin
                s2_rot_next.x = -s2_xs;
                s2_rot_next.y = -s2_ys;
            end
            QUAD_3: begin
                s2_rot_next.x = s2_ys;
                s2_rot_next.y = -s2_xs;
            end
            default: begin
                s2_rot_next.x = s2_xs;
                s2_rot_next.y = s2_ys;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (s2_rdy) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_rdy && s1_vld_reg) begin
            s2_rot_reg  <= s2_rot_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    assign cd_vld[0]  = s2_vld_reg;
    assign cd_rot[0]  = s2_rot_reg;
    assign cd_side[0] = s2_side_reg;
    assign cd_rdy[ROTATION_STAGES] = mul_rdy;

    for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cordic
        pft_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_vld   (cd_vld[i]),
            .in_rot   (cd_rot[i]),
            .in_side  (cd_side[i]),
            .in_rdy   (cd_rdy[i]),
            .out_vld  (cd_vld[i+1]),
            .out_rot  (cd_rot[i+1]),
            .out_side (cd_side[i+1]),
            .out_rdy  (cd_rdy[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else if (mul_rdy) begin
            mul_vld_reg <= cd_vld[ROTATION_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_rdy && cd_vld[ROTATION_STAGES]) begin
            mul_px_reg   <= cd_rot[ROTATION_STAGES].x * GAIN_Q20;
            mul_py_reg   <= cd_rot[ROTATION_STAGES].y * GAIN_Q20;
            mul_side_reg <= cd_side[ROTATION_STAGES];
        end
    end

    assign rnd_x_next = RND_W'((mul_px_reg + RND_HALF) >>> SHIFT_TOTAL);
    assign rnd_y_next = RND_W'((mul_py_reg + RND_HALF) >>> SHIFT_TOTAL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_vld_reg <= 1'b0;
        end else if (rnd_rdy) begin
            rnd_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_rdy && mul_vld_reg) begin
            rnd_x_reg    <= rnd_x_next;
            rnd_y_reg    <= rnd_y_next;
            rnd_side_reg <= mul_side_reg;
        end
    end

    always_comb begin
        if (rnd_side_reg.op == OP_L2G) begin
            sum_x = SUM_W'(rnd_x_reg) + SUM_W'(rnd_side_reg.ref_x);
            sum_y = SUM_W'(rnd_y_reg) + SUM_W'(rnd_side_reg.ref_y);
        end else begin
            sum_x = SUM_W'(rnd_x_reg);
            sum_y = SUM_W'(rnd_y_reg);
        end
        if (sum_x > SAT_HI) begin
            out_x_next = COORD_IN_W'(SAT_HI);
        end else if (sum_x < SAT_LO) begin
            out_x_next = COORD_IN_W'(SAT_LO);
        end else begin
            out_x_next = COORD_IN_W'(sum_x);
        end
        if (sum_y > SAT_HI) begin
            out_y_next = COORD_IN_W'(SAT_HI);
        end else if (sum_y < SAT_LO) begin
            out_y_next = COORD_IN_W'(SAT_LO);
        end else begin
            out_y_next = COORD_IN_W'(sum_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_rdy) begin
            out_vld_reg <= rnd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && rnd_vld_reg) begin
            out_op_reg        <= rnd_side_reg.op;
            out_x_reg         <= out_x_next;
            out_y_reg         <= out_y_next;
            out_heading_reg   <= rnd_side_reg.heading;
            out_curvature_reg <= rnd_side_reg.curvature;
            out_arc_reg       <= rnd_side_reg.arc_length;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_out_x          = out_x_reg;
    assign m_out_y          = out_y_reg;
    assign m_out_heading    = out_heading_reg;
    assign m_out_curvature  = $signed(out_curvature_reg);
    assign m_out_arc_length = $signed(out_arc_reg);

    // The input side stalls only when every stage is full and the output is blocked.
    `ASSERT_IMPLIES(a_stall_only_when_full, !s_ready, m_valid && !m_ready, "input stalled with room in pipeline")
    // A global-to-local item always leaves with a zero arc length.
    `ASSERT_IMPLIES(a_g2l_arc_zero, m_valid && (out_op_reg == OP_G2L), m_out_arc_length == '0, "nonzero arc length on global-to-local item")
    // Positions never leave the saturation range.
    `ASSERT_IMPLIES(a_sat_range, m_valid, ($signed(m_out_x) <= SAT_HI) && ($signed(m_out_x) >= SAT_LO) && ($signed(m_out_y) <= SAT_HI) && ($signed(m_out_y) >= SAT_LO), "position outside saturation range")

endmodule

`default_nettype wire

// ===== tb/sv/pose_frame_transform_unit_test.sv =====
// Self-checking testbench for the pose frame transform unit, with a built-in transform predictor.
module pose_frame_transform_unit_test;
    import pft_pkg::*;

    localparam int ROT_STAGES   = 16;
    localparam int PIPE_LATENCY = ROT_STAGES + 5;
    localparam int RANDOM_ITEMS = 930;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 40;

    localparam longint GAIN_CORR  = 636751;
    localparam longint ROUND_HALF = 134217728;
    localparam int     GAIN_DROP  = 28;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct {
        logic                         op;
        logic signed [COORD_IN_W-1:0] ref_x;
        logic signed [COORD_IN_W-1:0] ref_y;
        logic        [HEAD_W-1:0]     ref_heading;
        logic signed [COORD_IN_W-1:0] tgt_x;
        logic signed [COORD_IN_W-1:0] tgt_y;
        logic        [HEAD_W-1:0]     tgt_heading;
        logic signed [COORD_IN_W-1:0] tgt_curvature;
        logic signed [COORD_IN_W-1:0] tgt_arc_length;
    } pose_pair_t;

    typedef struct {
        pose_pair_t pose;
        int         gap;
        bit         drain_first;
    } queued_pose_t;

    typedef struct {
        logic signed [COORD_IN_W-1:0] x;
        logic signed [COORD_IN_W-1:0] y;
        logic        [HEAD_W-1:0]     heading;
        logic signed [COORD_IN_W-1:0] curvature;
        logic signed [COORD_IN_W-1:0] arc_length;
    } frame_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_operation = OP_L2G;
    logic signed [COORD_IN_W-1:0] s_ref_x = '0;
    logic signed [COORD_IN_W-1:0] s_ref_y = '0;
    logic        [HEAD_W-1:0]     s_ref_heading = '0;
    logic signed [COORD_IN_W-1:0] s_tgt_x = '0;
    logic signed [COORD_IN_W-1:0] s_tgt_y = '0;
    logic        [HEAD_W-1:0]     s_tgt_heading = '0;
    logic signed [COORD_IN_W-1:0] s_tgt_curvature = '0;
    logic signed [COORD_IN_W-1:0] s_tgt_arc_length = '0;

    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [COORD_IN_W-1:0] m_out_x;
    logic signed [COORD_IN_W-1:0] m_out_y;
    logic        [HEAD_W-1:0]     m_out_heading;
    logic signed [COORD_IN_W-1:0] m_out_curvature;
    logic signed [COORD_IN_W-1:0] m_out_arc_length;

    queued_pose_t  pending_poses[$];
    frame_result_t predicted_frames[$];

    logic s_take = 1'b0;
    logic m_take = 1'b0;
    int   accepted_count = 0;
    int   queued_count = 0;
    int   mismatch_count = 0;
    int   send_calm = 0;
    int   recv_calm = 0;
    int   recv_stall = 0;
    int   cycles;

    pose_frame_transform_unit #(
        .ROTATION_STAGES(ROT_STAGES),
        .COORD_WIDTH    (32)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_ref_x         (s_ref_x),
        .s_ref_y         (s_ref_y),
        .s_ref_heading   (s_ref_heading),
        .s_tgt_x         (s_tgt_x),
        .s_tgt_y         (s_tgt_y),
        .s_tgt_heading   (s_tgt_heading),
        .s_tgt_curvature (s_tgt_curvature),
        .s_tgt_arc_length(s_tgt_arc_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_heading   (m_out_heading),
        .m_out_curvature (m_out_curvature),
        .m_out_arc_length(m_out_arc_length)
    );

    function automatic void cordic_rotate(input longint vx, input longint vy,
                                          input logic [31:0] angle,
                                          output longint rx, output longint ry);
        longint x, y, t, r, dx, dy;
        int     s;
        x = vx * 256;
        y = vy * 256;
        case (angle[31:30])
            QUAD_1: begin
                t = x;
                x = -y;
                y = t;
            end
            QUAD_2: begin
                x = -x;
                y = -y;
            end
            QUAD_3: begin
                t = x;
                x = y;
                y = -t;
            end
            default: begin
            end
        endcase
        r = longint'(angle[29:0]);
        for (int i = 0; i < ROT_STAGES; i++) begin
            s = i % 32;
            dx = y >>> s;
            dy = x >>> s;
            if (r >= 0) begin
                x = x - dx;
                y = y + dy;
                r = r - longint'(ATAN_TURNS[s]);
            end else begin
                x = x + dx;
                y = y - dy;
                r = r + longint'(ATAN_TURNS[s]);
            end
        end
        rx = (x * GAIN_CORR + ROUND_HALF) >>> GAIN_DROP;
        ry = (y * GAIN_CORR + ROUND_HALF) >>> GAIN_DROP;
    endfunction

    function automatic logic [31:0] clamp_coord(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic frame_result_t transform_pose(input pose_pair_t p);
        frame_result_t res;
        longint        rx, ry;
        logic [31:0]   angle;
        angle = {p.ref_heading, 16'd0};
        res.curvature = p.tgt_curvature;
        if (p.op == OP_L2G) begin
            cordic_rotate(longint'(p.tgt_x), longint'(p.tgt_y), angle, rx, ry);
            rx = rx + longint'(p.ref_x);
            ry = ry + longint'(p.ref_y);
            res.heading = p.ref_heading + p.tgt_heading;
            res.arc_length = p.tgt_arc_length;
        end else begin
            cordic_rotate(longint'(p.tgt_x) - longint'(p.ref_x),
                          longint'(p.tgt_y) - longint'(p.ref_y),
                          32'd0 - angle, rx, ry);
            res.heading = p.tgt_heading - p.ref_heading;
            res.arc_length = '0;
        end
        res.x = clamp_coord(rx);
        res.y = clamp_coord(ry);
        return res;
    endfunction

    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 4))
            0: v[31:20] = {12{v[19]}};
            1: v = 32'h7FFFFFFF - $urandom_range(0, 4095);
            2: v = 32'h80000000 + $urandom_range(0, 4095);
            3: v[31:26] = {6{v[25]}};
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_heading();
        if ($urandom_range(0, 3) == 0)
            return {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 16)) - 16'd8;
        return 16'($urandom());
    endfunction

    function automatic pose_pair_t make_pose(input logic op,
                                            input logic [31:0] rx, input logic [31:0] ry,
                                            input logic [15:0] rh,
                                            input logic [31:0] tx, input logic [31:0] ty,
                                            input logic [15:0] th,
                                            input logic [31:0] curv, input logic [31:0] arc);
        pose_pair_t p;
        p.op = op;
        p.ref_x = rx;
        p.ref_y = ry;
        p.ref_heading = rh;
        p.tgt_x = tx;
        p.tgt_y = ty;
        p.tgt_heading = th;
        p.tgt_curvature = curv;
        p.tgt_arc_length = arc;
        return p;
    endfunction

    task automatic queue_pose(input pose_pair_t p, input bit drain_first);
        queued_pose_t q;
        q.pose = p;
        q.gap = draw_idle(send_calm);
        q.drain_first = drain_first;
        pending_poses.push_back(q);
        queued_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Sender: presents the queue head after its idle gap and, if so marked, once no result is outstanding.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_take) begin
            if (pending_poses.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_poses[0].gap > 0) begin
                pending_poses[0].gap--;
                s_valid <= 1'b0;
            end else if (pending_poses[0].drain_first && predicted_frames.size() != 0) begin
                s_valid <= 1'b0;
            end else begin
                queued_pose_t q;
                q = pending_poses.pop_front();
                s_valid <= 1'b1;
                s_operation <= q.pose.op;
                s_ref_x <= q.pose.ref_x;
                s_ref_y <= q.pose.ref_y;
                s_ref_heading <= q.pose.ref_heading;
                s_tgt_x <= q.pose.tgt_x;
                s_tgt_y <= q.pose.tgt_y;
                s_tgt_heading <= q.pose.tgt_heading;
                s_tgt_curvature <= q.pose.tgt_curvature;
                s_tgt_arc_length <= q.pose.tgt_arc_length;
            end
        end
    end

    // Receiver: after each taken item, draws a random stall, possibly none, and holds m_ready low through it.
    always @(negedge aclk) begin
        int stall;
        stall = m_take ? draw_idle(recv_calm) : recv_stall;
        if (stall > 0) begin
            m_ready <= 1'b0;
            recv_stall <= stall - 1;
        end else begin
            m_ready <= 1'b1;
            recv_stall <= 0;
        end
    end

    always @(posedge aclk) begin
        pose_pair_t    p;
        frame_result_t want;
        s_take <= aresetn && s_valid && s_ready;
        m_take <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            p = make_pose(s_operation, s_ref_x, s_ref_y, s_ref_heading, s_tgt_x, s_tgt_y,
                          s_tgt_heading, s_tgt_curvature, s_tgt_arc_length);
            predicted_frames.push_back(transform_pose(p));
            accepted_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (predicted_frames.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected item: expected none, actual x %h y %h",
                             $time, m_out_x, m_out_y);
                mismatch_count++;
            end else begin
                want = predicted_frames.pop_front();
                check_field("x", want.x, m_out_x);
                check_field("y", want.y, m_out_y);
                check_field("heading", {16'd0, want.heading}, {16'd0, m_out_heading});
                check_field("curvature", want.curvature, m_out_curvature);
                check_field("arc_length", want.arc_length, m_out_arc_length);
            end
        end
    end

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        pose_pair_t p;
        int         n;

        queue_pose(make_pose(OP_L2G, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_pose(make_pose(OP_G2L, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_pose(make_pose(OP_L2G, 32'h00010000, 32'hFFFF0000, 16'h4000,
                             32'h00010000, 0, 16'h0100, 32'h00001000, 32'h00020000), 1'b0);
        queue_pose(make_pose(OP_L2G, 0, 0, 16'h8000, 32'h00030000, 32'h00050000,
                             16'h8000, 0, 32'h00010000), 1'b0);
        queue_pose(make_pose(OP_L2G, 0, 0, 16'hC000, 32'hFFFD0000, 32'h00050000,
                             16'h1234, 0, 0), 1'b0);
        queue_pose(make_pose(OP_L2G, 32'h12345678, 32'h87654321, 16'hFFFF,
                             32'h01000000, 32'hFF000000, 16'hFFFF, 0, 0), 1'b0);
        queue_pose(make_pose(OP_G2L, 32'h00100000, 32'h00200000, 16'h4000,
                             32'h00300000, 32'h00100000, 16'h2000, 32'h7FFFFFFF,
                             32'h7FFFFFFF), 1'b0);
        queue_pose(make_pose(OP_L2G, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0);
        queue_pose(make_pose(OP_L2G, 32'h80000000, 32'h80000000, 0,
                             32'h80000000, 32'h80000000, 0, 32'h80000000, 32'h80000000), 1'b0);
        queue_pose(make_pose(OP_G2L, 32'h80000000, 32'h80000000, 16'h2000,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000, 32'h80000000,
                             32'h80000000), 1'b0);
        queue_pose(make_pose(OP_G2L, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hE000,
                             32'h80000000, 32'h80000000, 16'hFFFF, 32'hFFFFFFFF,
                             32'hFFFFFFFF), 1'b0);
        queue_pose(make_pose(OP_L2G, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                             32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF,
                             32'hFFFFFFFF), 1'b0);
        queue_pose(make_pose(OP_G2L, 32'h00000001, 32'h00000001, 16'h0001,
                             32'h00000001, 32'h00000001, 16'h0000, 32'h00000001,
                             32'h00000001), 1'b0);
        queue_pose(make_pose(OP_L2G, 0, 0, 16'h2000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             16'h0001, 32'h55555555, 32'hAAAAAAAA), 1'b0);
        queue_pose(make_pose(OP_G2L, 0, 0, 16'h6000, 32'h80000000, 32'h7FFFFFFF,
                             16'h8000, 32'hAAAAAAAA, 32'h55555555), 1'b0);
        queue_pose(make_pose(OP_L2G, 32'h40000000, 32'hC0000000, 16'h0001,
                             32'h00010000, 32'h00010000, 16'h0001, 0, 0), 1'b0);
        queue_pose(make_pose(OP_G2L, 32'h0ABCDEF0, 32'hF0123456, 16'h0000,
                             32'h0ABCDEF0, 32'hF0123456, 16'h7FFF, 32'h00000100,
                             32'h00000200), 1'b0);
        queue_pose(make_pose(OP_G2L, 32'h00050000, 32'hFFFB0000, 16'h3FFF,
                             32'hFFF00000, 32'h00100000, 16'hC001, 0, 32'h12345678), 1'b0);
        queue_pose(make_pose(OP_L2G, 0, 0, 16'hBFFF, 32'h7FFFFFFF, 32'h80000000,
                             16'h4001, 0, 0), 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            p.op = $urandom_range(0, 1) ? OP_G2L : OP_L2G;
            p.ref_x = rand_coord();
            p.ref_y = rand_coord();
            p.ref_heading = rand_heading();
            p.tgt_x = rand_coord();
            p.tgt_y = rand_coord();
            p.tgt_heading = rand_heading();
            p.tgt_curvature = $urandom();
            p.tgt_arc_length = $urandom();
            queue_pose(p, (i % 250) == 0);
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < queued_count || predicted_frames.size() != 0)
            @(posedge aclk);
        n = 2 * PIPE_LATENCY + 16;
        repeat (n) @(posedge aclk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
